// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int ADDR_W = 14;
	localparam int SIZE_W = 15;
	localparam int PROMPT_W = 7;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = SIZE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_COLUMNS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_ATTRIBUTE = 2'd3;

	localparam logic [ADDR_W-1:0] RST_REGION_BASE = 14'd0;
	localparam logic [SIZE_W-1:0] RST_REGION_SIZE = 15'd16384;
	localparam logic [PROMPT_W-1:0] RST_PROMPT_COLUMNS = 7'd4;
	localparam logic [BYTE_W-1:0] RST_ERASE_ATTRIBUTE = 8'd7;

	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam int TAB_WIDTH = 4;
	localparam int TAB_W = $clog2(TAB_WIDTH);
	localparam logic [TAB_W-1:0] TAB_LAST = TAB_W'(TAB_WIDTH - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		OP_PRINT     = 4'b0001,
		OP_NEWLINE   = 4'b0010,
		OP_BACKSPACE = 4'b0100,
		OP_TAB       = 4'b1000
	} tccw_op_t;

	typedef struct packed {
		logic [BYTE_W-1:0] char_code;
		logic [BYTE_W-1:0] color;
	} tccw_req_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_address;
		logic [BYTE_W-1:0] write_char;
		logic [BYTE_W-1:0] write_color;
		logic [ADDR_W-1:0] cursor_position;
		logic [ADDR_W-1:0] display_start;
		logic              last;
	} tccw_rsp_t;

	typedef struct packed {
		tccw_op_t          op;
		logic [BYTE_W-1:0] char_code;
		logic [BYTE_W-1:0] color;
	} tccw_item_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} tccw_cfg_t;

endpackage

// ----- rtl/tccw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Takes character requests, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module tccw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  tccw_pkg::tccw_req_t  req,
	output logic                 push,
	output tccw_pkg::tccw_item_t item,
	input  logic                 queue_full
);

	logic                 valid_s1;
	tccw_pkg::tccw_item_t item_s1;
	tccw_pkg::tccw_op_t   op_class;

	always_comb begin
		unique case (req.char_code)
			tccw_pkg::CH_NEWLINE:   op_class = tccw_pkg::OP_NEWLINE;
			tccw_pkg::CH_BACKSPACE: op_class = tccw_pkg::OP_BACKSPACE;
			tccw_pkg::CH_TAB:       op_class = tccw_pkg::OP_TAB;
			default:                op_class = tccw_pkg::OP_PRINT;
		endcase
	end

	assign req_stall = valid_s1 && queue_full;
	assign push = valid_s1 && !queue_full;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.op <= op_class;
			item_s1.char_code <= req.char_code;
			item_s1.color <= req.color;
		end
	end

endmodule

// ----- rtl/tccw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module tccw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tccw_pkg::tccw_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output tccw_pkg::tccw_item_t head
);

	tccw_pkg::tccw_item_t              entry_q [tccw_pkg::QUEUE_DEPTH];
	logic [tccw_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tccw_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tccw_pkg::QCNT_W-1:0]       count_q;
	logic                              do_pop;

	assign full = count_q == tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head = entry_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/tccw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Executes queued requests: cursor, cell writes, window scroll, results.
// ----------------------------------------------------------------------------
module tccw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int VMEM_WORDS = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tccw_pkg::tccw_cfg_t  cfg,
	input  logic                 head_valid,
	input  tccw_pkg::tccw_item_t head,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tccw_pkg::tccw_rsp_t  rsp
);

	localparam int WW = $clog2(2 ** tccw_pkg::ADDR_W + 2 ** tccw_pkg::SIZE_W + VMEM_WORDS
		+ COLUMNS * (ROWS + 1)) + 1;
	localparam int CW = $clog2(COLUMNS);
	localparam logic [WW-1:0] ONE = WW'(1);
	localparam logic [WW-1:0] COLS = WW'(COLUMNS);
	localparam logic [WW-1:0] SCREEN = WW'(COLUMNS * ROWS);
	localparam logic [WW-1:0] VMEM_CAP = WW'(VMEM_WORDS);
	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

	typedef enum logic [1:0] {
		ST_EXEC   = 2'b01,
		ST_SCROLL = 2'b10
	} state_t;

	state_t                           state_q;
	logic [tccw_pkg::ADDR_W-1:0]      base_q;
	logic [tccw_pkg::SIZE_W-1:0]      size_q;
	logic [tccw_pkg::PROMPT_W-1:0]    prompt_q;
	logic [tccw_pkg::BYTE_W-1:0]      erase_q;
	logic [WW-1:0]                    end_q;
	logic [WW-1:0]                    cursor_q;
	logic [WW-1:0]                    ws_q;
	logic [WW-1:0]                    top_q;
	logic [CW-1:0]                    col_q;
	logic [tccw_pkg::TAB_W-1:0]       sub_q;
	tccw_pkg::tccw_rsp_t              pend_q;
	logic                             rsp_valid_q;
	tccw_pkg::tccw_rsp_t              rsp_q;

	logic [WW-1:0]                    cursor_n;
	logic [CW-1:0]                    col_n;
	logic                             we;
	logic [WW-1:0]                    waddr;
	logic [tccw_pkg::BYTE_W-1:0]      wch;
	logic [tccw_pkg::BYTE_W-1:0]      wcol;
	logic                             is_last;
	logic [WW-1:0]                    cur_chk;
	logic [WW-1:0]                    top2;
	logic                             step;
	logic                             more;
	logic [WW-1:0]                    ws_n;
	logic [WW-1:0]                    top_n;
	logic                             out_free;
	logic                             go;
	logic                             emit;
	tccw_pkg::tccw_rsp_t              cand;
	logic [WW-1:0]                    cfg_end_sum;

	always_comb begin
		cursor_n = cursor_q;
		col_n = col_q;
		we = 1'b0;
		waddr = cursor_q;
		wch = head.char_code;
		wcol = head.color;
		unique case (head.op) inside
			tccw_pkg::OP_PRINT, tccw_pkg::OP_TAB: begin
				if (head.op == tccw_pkg::OP_TAB) begin
					wch = tccw_pkg::CH_SPACE;
				end
				if (cursor_q + ONE < end_q) begin
					we = 1'b1;
					cursor_n = cursor_q + ONE;
					col_n = (col_q == COL_LAST) ? '0 : col_q + 1'b1;
				end
			end
			tccw_pkg::OP_NEWLINE: begin
				if (cursor_q + COLS < end_q) begin
					cursor_n = cursor_q - WW'(col_q) + COLS;
					col_n = '0;
				end
			end
			tccw_pkg::OP_BACKSPACE: begin
				wch = tccw_pkg::CH_SPACE;
				wcol = erase_q;
				if (WW'(col_q) > WW'(prompt_q)) begin
					we = 1'b1;
					cursor_n = cursor_q - ONE;
					col_n = col_q - 1'b1;
					waddr = cursor_q - ONE;
				end
			end
			default: ;
		endcase
	end

	assign is_last = (head.op != tccw_pkg::OP_TAB) || (sub_q == tccw_pkg::TAB_LAST);

	// window scroll, one row a cycle while the output is not stalled
	assign cur_chk = (state_q == ST_EXEC) ? cursor_n : cursor_q;
	assign top2 = top_q + COLS;
	assign step = (state_q == ST_SCROLL) || (cur_chk >= top_q && top_q < end_q);
	assign more = step && cur_chk >= top2 && top2 < end_q;
	assign ws_n = step ? ws_q + COLS : ws_q;
	assign top_n = step ? top2 : top_q;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign go = out_free && (state_q == ST_SCROLL || head_valid);
	assign emit = go && !more;

	always_comb begin
		if (state_q == ST_EXEC) begin
			cand.write_enable = we;
			cand.write_address = we ? waddr[tccw_pkg::ADDR_W-1:0] : '0;
			cand.write_char = we ? wch : '0;
			cand.write_color = we ? wcol : '0;
			cand.last = is_last;
		end else begin
			cand = pend_q;
		end
		cand.cursor_position = cur_chk[tccw_pkg::ADDR_W-1:0];
		cand.display_start = ws_n[tccw_pkg::ADDR_W-1:0];
	end

	assign pop = emit && cand.last;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign cfg_end_sum = (cfg.index == tccw_pkg::CFG_REGION_BASE)
		? WW'(cfg.data[tccw_pkg::ADDR_W-1:0]) + WW'(size_q)
		: WW'(base_q) + WW'(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXEC;
			base_q <= tccw_pkg::RST_REGION_BASE;
			size_q <= tccw_pkg::RST_REGION_SIZE;
			prompt_q <= tccw_pkg::RST_PROMPT_COLUMNS;
			erase_q <= tccw_pkg::RST_ERASE_ATTRIBUTE;
			end_q <= (WW'(tccw_pkg::RST_REGION_BASE) + WW'(tccw_pkg::RST_REGION_SIZE) > VMEM_CAP)
				? VMEM_CAP : WW'(tccw_pkg::RST_REGION_BASE) + WW'(tccw_pkg::RST_REGION_SIZE);
			cursor_q <= WW'(tccw_pkg::RST_REGION_BASE);
			ws_q <= WW'(tccw_pkg::RST_REGION_BASE);
			top_q <= WW'(tccw_pkg::RST_REGION_BASE) + SCREEN;
			col_q <= '0;
			sub_q <= '0;
			rsp_valid_q <= 1'b0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				tccw_pkg::CFG_REGION_BASE: begin
					base_q <= cfg.data[tccw_pkg::ADDR_W-1:0];
					cursor_q <= WW'(cfg.data[tccw_pkg::ADDR_W-1:0]);
					ws_q <= WW'(cfg.data[tccw_pkg::ADDR_W-1:0]);
					top_q <= WW'(cfg.data[tccw_pkg::ADDR_W-1:0]) + SCREEN;
					col_q <= '0;
					end_q <= (cfg_end_sum > VMEM_CAP) ? VMEM_CAP : cfg_end_sum;
				end
				tccw_pkg::CFG_REGION_SIZE: begin
					size_q <= cfg.data;
					end_q <= (cfg_end_sum > VMEM_CAP) ? VMEM_CAP : cfg_end_sum;
				end
				tccw_pkg::CFG_PROMPT_COLUMNS: begin
					prompt_q <= cfg.data[tccw_pkg::PROMPT_W-1:0];
				end
				tccw_pkg::CFG_ERASE_ATTRIBUTE: begin
					erase_q <= cfg.data[tccw_pkg::BYTE_W-1:0];
				end
				default: ;
			endcase
		end else begin
			if (go) begin
				ws_q <= ws_n;
				top_q <= top_n;
				if (state_q == ST_EXEC) begin
					cursor_q <= cursor_n;
					col_q <= col_n;
				end
				state_q <= more ? ST_SCROLL : ST_EXEC;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
				sub_q <= cand.last ? '0 : sub_q + 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && state_q == ST_EXEC && more) begin
			pend_q <= cand;
		end
		if (emit) begin
			rsp_q <= cand;
		end
	end

	a_top_tracks_window: assert property (@(posedge clk) disable iff (!arst_n)
		top_q == ws_q + SCREEN)
		else $error("window end out of step with window start");

	a_cursor_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q >= WW'(base_q))
		else $error("cursor below region base");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < COLS)
		else $error("column counter out of range");

	a_scroll_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCROLL |-> head_valid)
		else $error("scrolling with no request at the queue head");

endmodule

// ----- rtl/text_console_char_writer.sv -----
`timescale 1ns / 1ps
// a request passes the front stage register, the queue and the result register
// throughput: one request per cycle unless the output stalls; a tab gives four results
// scrolling over more than one row holds off the next request (after a region resize only)
// reset: cursor and display start go to the region base, registers to their reset values
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console cursor and scroll unit: turns characters into cell writes.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int VMEM_WORDS = 16384
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tccw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  tccw_pkg::tccw_req_t                req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output tccw_pkg::tccw_rsp_t                rsp
);

	logic                 push;
	tccw_pkg::tccw_item_t push_item;
	logic                 queue_full;
	logic                 pop;
	logic                 head_valid;
	tccw_pkg::tccw_item_t head;
	tccw_pkg::tccw_cfg_t  cfg;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	tccw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push       (push),
		.item       (push_item),
		.queue_full (queue_full)
	);

	tccw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tccw_back #(
		.COLUMNS    (COLUMNS),
		.ROWS       (ROWS),
		.VMEM_WORDS (VMEM_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

// ----- tb/tb_text_console_char_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Self-checking bench for the text console character writer: directed checks
// of each character kind, the region end and a region shrink, then random
// text under varied handshake idling, all scored against a cycle-free
// cursor and window predictor.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int VMEM_WORDS = 16384;
	localparam int SCREEN_WORDS = COLUMNS * ROWS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	tccw_pkg::tccw_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	tccw_pkg::tccw_rsp_t rsp;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// predictor state
	int unsigned con_base = tccw_pkg::RST_REGION_BASE;
	int unsigned con_size = tccw_pkg::RST_REGION_SIZE;
	int unsigned con_prompt = tccw_pkg::RST_PROMPT_COLUMNS;
	int unsigned con_erase = tccw_pkg::RST_ERASE_ATTRIBUTE;
	int unsigned cursor = tccw_pkg::RST_REGION_BASE;
	int unsigned window = tccw_pkg::RST_REGION_BASE;
	tccw_pkg::tccw_rsp_t expected_cells[$];
	tccw_pkg::tccw_rsp_t want;

	text_console_char_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.VMEM_WORDS(VMEM_WORDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic int unsigned region_limit();
		int unsigned e;
		e = con_base + con_size;
		return (e > VMEM_WORDS) ? VMEM_WORDS : e;
	endfunction

	function automatic void follow_cursor();
		int unsigned lim;
		int unsigned top;
		int unsigned need;
		int unsigned room;
		lim = region_limit();
		top = window + SCREEN_WORDS;
		if (cursor >= top && top < lim) begin
			need = (cursor - top) / COLUMNS + 1;
			room = (lim - top + COLUMNS - 1) / COLUMNS;
			window += ((need < room) ? need : room) * COLUMNS;
		end
	endfunction

	function automatic void log_cell(bit we, int unsigned addr,
			logic [tccw_pkg::BYTE_W-1:0] ch, logic [tccw_pkg::BYTE_W-1:0] attr,
			bit is_last);
		tccw_pkg::tccw_rsp_t c;
		c.write_enable = we;
		c.write_address = we ? tccw_pkg::ADDR_W'(addr) : '0;
		c.write_char = we ? ch : '0;
		c.write_color = we ? attr : '0;
		c.cursor_position = tccw_pkg::ADDR_W'(cursor);
		c.display_start = tccw_pkg::ADDR_W'(window);
		c.last = is_last;
		expected_cells.push_back(c);
	endfunction

	function automatic void put_glyph(logic [tccw_pkg::BYTE_W-1:0] ch,
			logic [tccw_pkg::BYTE_W-1:0] attr, bit is_last);
		bit we;
		int unsigned addr;
		we = 1'b0;
		addr = cursor;
		if (cursor + 1 < region_limit()) begin
			we = 1'b1;
			cursor++;
		end
		follow_cursor();
		log_cell(we, addr, ch, attr, is_last);
	endfunction

	function automatic void predict_char(logic [tccw_pkg::BYTE_W-1:0] code,
			logic [tccw_pkg::BYTE_W-1:0] attr);
		bit we;
		case (code)
			tccw_pkg::CH_TAB: begin
				for (int i = 0; i < tccw_pkg::TAB_WIDTH; i++)
					put_glyph(tccw_pkg::CH_SPACE, attr, i == tccw_pkg::TAB_WIDTH - 1);
			end
			tccw_pkg::CH_NEWLINE: begin
				if (cursor >= con_base && cursor + COLUMNS < region_limit())
					cursor = con_base + COLUMNS * ((cursor - con_base) / COLUMNS + 1);
				follow_cursor();
				log_cell(1'b0, 0, '0, '0, 1'b1);
			end
			tccw_pkg::CH_BACKSPACE: begin
				we = 1'b0;
				if (cursor >= con_base && (cursor - con_base) % COLUMNS > con_prompt) begin
					cursor--;
					we = 1'b1;
				end
				follow_cursor();
				log_cell(we, cursor, tccw_pkg::CH_SPACE, tccw_pkg::BYTE_W'(con_erase), 1'b1);
			end
			default: begin
				put_glyph(code, attr, 1'b1);
			end
		endcase
	endfunction

	function automatic void apply_reg(logic [tccw_pkg::CFG_IDX_W-1:0] idx,
			int unsigned value);
		case (idx)
			tccw_pkg::CFG_REGION_BASE: begin
				con_base = value & 32'h3FFF;
				cursor = con_base;
				window = con_base;
			end
			tccw_pkg::CFG_REGION_SIZE: con_size = value & 32'h7FFF;
			tccw_pkg::CFG_PROMPT_COLUMNS: con_prompt = value & 32'h7F;
			tccw_pkg::CFG_ERASE_ATTRIBUTE: con_erase = value & 32'hFF;
			default: ;
		endcase
	endfunction

	task automatic report(string what, tccw_pkg::tccw_rsp_t got,
			tccw_pkg::tccw_rsp_t exp_cell);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t %s (expected/got): we %0d/%0d addr %0h/%0h char %0h/%0h",
				$realtime, what, exp_cell.write_enable, got.write_enable,
				exp_cell.write_address, got.write_address,
				exp_cell.write_char, got.write_char);
			$display("  color %0h/%0h cursor %0h/%0h start %0h/%0h last %0d/%0d",
				exp_cell.write_color, got.write_color,
				exp_cell.cursor_position, got.cursor_position,
				exp_cell.display_start, got.display_start, exp_cell.last, got.last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_cells.size() == 0) begin
				report("unexpected result", rsp, '0);
			end else begin
				want = expected_cells.pop_front();
				if (rsp.write_enable !== want.write_enable ||
						rsp.write_address !== want.write_address ||
						rsp.write_char !== want.write_char ||
						rsp.write_color !== want.write_color ||
						rsp.cursor_position !== want.cursor_position ||
						rsp.display_start !== want.display_start ||
						rsp.last !== want.last)
					report("result mismatch", rsp, want);
			end
		end
	end

	task automatic send_char(logic [tccw_pkg::BYTE_W-1:0] code,
			logic [tccw_pkg::BYTE_W-1:0] attr);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		predict_char(code, attr);
		req <= '{char_code: code, color: attr};
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_cells.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [tccw_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= tccw_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic set_console(int unsigned base, int unsigned size, int unsigned prompt,
			int unsigned erase);
		drain();
		write_reg(tccw_pkg::CFG_REGION_BASE, base);
		write_reg(tccw_pkg::CFG_REGION_SIZE, size);
		write_reg(tccw_pkg::CFG_PROMPT_COLUMNS, prompt);
		write_reg(tccw_pkg::CFG_ERASE_ATTRIBUTE, erase);
	endtask

	// reset settings: each kind of character and the prompt boundary
	task automatic test_each_operation();
		send_char(8'h00, 8'hFF);
		send_char(8'hFF, 8'h00);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h11);
		send_char(tccw_pkg::CH_TAB, 8'hA5);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h22);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h33);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h44);
		send_char(tccw_pkg::CH_NEWLINE, 8'h55);
		send_char(8'h7E, 8'h5A);
	endtask

	// cursor at the top of video memory, full region and one-word region
	task automatic test_region_end();
		set_console(16300, 16384, 0, 255);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h01);
		send_char(tccw_pkg::CH_NEWLINE, 8'h02);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h03);
		repeat (4) send_char(8'h78, 8'h1E);
		send_char(tccw_pkg::CH_TAB, 8'h0F);
		send_char(tccw_pkg::CH_NEWLINE, 8'h04);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h05);
		set_console(16383, 16384, 0, 255);
		send_char(8'h41, 8'hF0);
		send_char(tccw_pkg::CH_TAB, 8'h0F);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h06);
	endtask

	// scroll past one screen, then shrink the region under the cursor
	task automatic test_size_rewrite();
		set_console(0, 16384, 0, 7);
		repeat (26) send_char(tccw_pkg::CH_NEWLINE, 8'h00);
		send_char(tccw_pkg::CH_TAB, 8'h3C);
		drain();
		write_reg(tccw_pkg::CFG_REGION_SIZE, 2000);
		send_char(tccw_pkg::CH_NEWLINE, 8'h00);
		send_char(8'h42, 8'h3C);
		send_char(tccw_pkg::CH_BACKSPACE, 8'h00);
	endtask

	task automatic test_random_text(int sender_idle, int receiver_idle, int unsigned base,
			int unsigned size, int unsigned prompt, int unsigned erase, int count);
		int r;
		tccw_pkg::tccw_op_t op;
		logic [tccw_pkg::BYTE_W-1:0] code;
		set_console(base, size, prompt, erase);
		send_idle_pct <= sender_idle;
		recv_stall_pct <= receiver_idle;
		@(posedge clk);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			op = (r < 30) ? tccw_pkg::OP_NEWLINE : (r < 45) ? tccw_pkg::OP_BACKSPACE
				: (r < 55) ? tccw_pkg::OP_TAB : tccw_pkg::OP_PRINT;
			case (op)
				tccw_pkg::OP_NEWLINE: code = tccw_pkg::CH_NEWLINE;
				tccw_pkg::OP_BACKSPACE: code = tccw_pkg::CH_BACKSPACE;
				tccw_pkg::OP_TAB: code = tccw_pkg::CH_TAB;
				default: code = tccw_pkg::BYTE_W'($urandom_range(255));
			endcase
			send_char(code, tccw_pkg::BYTE_W'($urandom_range(255)));
		end
	endtask

	initial begin
		send_idle_pct <= 34;
		recv_stall_pct <= 62;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_operation();
		test_region_end();
		test_size_rewrite();
		test_random_text(34, 62, 0, 2000, 0, 0, 72);
		test_random_text(62, 34, $urandom_range(8000), $urandom_range(2080, 2400),
			$urandom_range(6), $urandom_range(255), 72);
		test_random_text(0, 0, $urandom_range(2000), 16384, 79, 255, 72);
		drain();
		if (mismatches == 0 && expected_cells.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
